FILE: rtl/prle_pkg.sv
`default_nettype none

package prle_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int TABLE_AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TABLE_CW    = $clog2(TABLE_DEPTH + 1);

    typedef logic [2:0] mode_t;
    localparam mode_t MODE_START   = 3'd0;
    localparam mode_t MODE_TABLE   = 3'd1;
    localparam mode_t MODE_INDEX   = 3'd2;
    localparam mode_t MODE_RUN     = 3'd3;
    localparam mode_t MODE_LITERAL = 3'd4;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_RANGE  = 2'd1;
    localparam status_t ST_STREAM = 2'd2;
    localparam status_t ST_END    = 2'd3;

    typedef logic [1:0] phase_t;
    localparam phase_t PHASE_INDEX   = 2'd0;
    localparam phase_t PHASE_RUN     = 2'd1;
    localparam phase_t PHASE_LITERAL = 2'd2;

    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t CFG_FRAME_WIDTH  = 1'b0;
    localparam cfg_index_t CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [7:0] ESC_BYTE      = 8'hff;
    localparam logic [1:0] LIT_LAST_BYTE = 2'd3;

    typedef struct packed {
        logic [31:0] pair_value;
        logic [31:0] repeat_count;
        logic        frame_last;
        status_t     status;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/palette_run_length_expander.sv
// Palette run-length expander. A start beat (mode 0) clears the palette table and loads the
// frame length of ceil(frame_width * frame_height / 2) pixel pairs; table beats (mode 1)
// append pixel-pair words; index, run and literal byte beats (modes 2 to 4) then decode the
// frame, and each completed run or literal, or each error, gives one result beat carrying a
// pair, its repeat count, a frame_last flag and a status. One item is taken every cycle:
// each beat is decoded in the cycle it is accepted and its result goes to an output register
// backed by a one-entry skid register, so item_stall rises only when both are full. The
// palette word for a run is read from the table memory when its index completes, so the
// run byte that follows finds it in the memory's read register. Write configuration only
// while no result beat is pending; cfg_ready is always high.

`default_nettype none

module palette_run_length_expander (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire  prle_pkg::cfg_index_t cfg_index,
    input  wire  [15:0]          cfg_data,
    input  wire                  item_valid,
    output logic                 item_stall,
    input  wire  [2:0]           mode,
    input  wire  [31:0]          payload,
    output logic                 result_valid,
    input  wire                  result_stall,
    output logic [31:0]          pair_value,
    output logic [31:0]          repeat_count,
    output logic                 frame_last,
    output logic [1:0]           status
);

    import prle_pkg::*;

    logic [15:0]         frame_width_reg;
    logic [15:0]         frame_height_reg;
    logic [TABLE_CW-1:0] table_count_reg, table_count_next;
    phase_t              phase_reg, phase_next;
    logic [31:0]         acc_reg, acc_next;
    logic [23:0]         lit_bytes_reg, lit_bytes_next;
    logic [1:0]          lit_count_reg, lit_count_next;
    logic [31:0]         remain_reg, remain_next;

    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;

    logic    item_accept;
    logic    out_take;
    logic    res_gen;
    result_t res;

    logic                wr_en;
    logic                rd_en;
    logic [TABLE_AW-1:0] rd_addr;
    logic [31:0]         rd_data;

    logic [7:0]  byte_val;
    logic [32:0] acc_sum33;
    logic [31:0] acc_sum;
    logic        idx_in_table;
    logic [8:0]  byte_inc;
    logic [32:0] run_sum33;
    logic [31:0] run_val;
    logic [32:0] rem_diff33;
    logic [31:0] run_count;
    logic [31:0] run_remain;
    logic [31:0] pixels;
    logic [31:0] frame_pairs;
    phase_t      want_phase;

    assign cfg_ready    = 1'b1;
    assign item_stall   = skid_valid_reg;
    assign item_accept  = item_valid && !item_stall;
    assign out_take     = out_valid_reg && !result_stall;

    assign result_valid = out_valid_reg;
    assign pair_value   = out_reg.pair_value;
    assign repeat_count = out_reg.repeat_count;
    assign frame_last   = out_reg.frame_last;
    assign status       = out_reg.status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 16'd1;
            frame_height_reg <= 16'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign byte_val     = payload[7:0];
    assign acc_sum33    = {1'b0, acc_reg} + {25'd0, byte_val};
    assign acc_sum      = acc_sum33[32] ? 32'hffff_ffff : acc_sum33[31:0];
    assign idx_in_table = acc_sum <= {{(32 - TABLE_CW){1'b0}}, table_count_reg};
    assign rd_addr      = acc_sum[TABLE_AW-1:0] - TABLE_AW'(1);

    assign byte_inc   = {1'b0, byte_val} + 9'd1;
    assign run_sum33  = {1'b0, acc_reg} + {24'd0, byte_inc};
    assign run_val    = run_sum33[32] ? 32'hffff_ffff : run_sum33[31:0];
    assign rem_diff33 = {1'b0, remain_reg} - {1'b0, run_val};
    assign run_count  = rem_diff33[32] ? remain_reg : run_val;
    assign run_remain = rem_diff33[32] ? 32'd0 : rem_diff33[31:0];

    assign pixels      = {16'd0, frame_width_reg} * {16'd0, frame_height_reg};
    assign frame_pairs = {1'b0, pixels[31:1]} + {31'd0, pixels[0]};

    always_comb
    begin
        unique case (mode) inside
            MODE_INDEX: want_phase = PHASE_INDEX;
            MODE_RUN:   want_phase = PHASE_RUN;
            default:    want_phase = PHASE_LITERAL;
        endcase
    end

    always_comb
    begin
        table_count_next = table_count_reg;
        phase_next       = phase_reg;
        acc_next         = acc_reg;
        lit_bytes_next   = lit_bytes_reg;
        lit_count_next   = lit_count_reg;
        remain_next      = remain_reg;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        res_gen          = 1'b0;
        res              = '0;

        if (item_accept)
        begin
            unique case (mode) inside
                MODE_START:
                begin
                    remain_next      = frame_pairs;
                    table_count_next = '0;
                    phase_next       = PHASE_INDEX;
                    acc_next         = '0;
                    lit_bytes_next   = '0;
                    lit_count_next   = '0;
                end
                MODE_TABLE:
                begin
                    if (table_count_reg < TABLE_CW'(TABLE_DEPTH))
                    begin
                        wr_en            = 1'b1;
                        table_count_next = table_count_reg + 1'b1;
                    end
                end
                MODE_INDEX, MODE_RUN, MODE_LITERAL:
                begin
                    if (remain_reg == 32'd0)
                    begin
                        res_gen    = 1'b1;
                        res.status = ST_END;
                    end
                    else if (phase_reg != want_phase)
                    begin
                        res_gen    = 1'b1;
                        res.status = ST_STREAM;
                    end
                    else if (mode == MODE_INDEX)
                    begin
                        if (byte_val == ESC_BYTE)
                        begin
                            acc_next = acc_sum;
                        end
                        else
                        begin
                            acc_next = '0;
                            if (acc_sum == 32'd0)
                            begin
                                phase_next     = PHASE_LITERAL;
                                lit_bytes_next = '0;
                                lit_count_next = '0;
                            end
                            else if (!idx_in_table)
                            begin
                                remain_next    = '0;
                                phase_next     = PHASE_INDEX;
                                res_gen        = 1'b1;
                                res.frame_last = 1'b1;
                                res.status     = ST_RANGE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                phase_next = PHASE_RUN;
                            end
                        end
                    end
                    else if (mode == MODE_RUN)
                    begin
                        if (byte_val == ESC_BYTE)
                        begin
                            acc_next = acc_sum;
                        end
                        else
                        begin
                            acc_next         = '0;
                            phase_next       = PHASE_INDEX;
                            remain_next      = run_remain;
                            res_gen          = 1'b1;
                            res.pair_value   = rd_data;
                            res.repeat_count = run_count;
                            res.frame_last   = (run_remain == 32'd0);
                            res.status       = ST_OK;
                        end
                    end
                    else
                    begin
                        if (lit_count_reg != LIT_LAST_BYTE)
                        begin
                            case (lit_count_reg)
                                2'd0:    lit_bytes_next[7:0]   = byte_val;
                                2'd1:    lit_bytes_next[15:8]  = byte_val;
                                default: lit_bytes_next[23:16] = byte_val;
                            endcase
                            lit_count_next = lit_count_reg + 2'd1;
                        end
                        else
                        begin
                            lit_bytes_next   = '0;
                            lit_count_next   = '0;
                            phase_next       = PHASE_INDEX;
                            remain_next      = remain_reg - 32'd1;
                            res_gen          = 1'b1;
                            res.pair_value   = {byte_val, lit_bytes_reg};
                            res.repeat_count = 32'd1;
                            res.frame_last   = (remain_reg == 32'd1);
                            res.status       = ST_OK;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_count_reg <= '0;
            phase_reg       <= PHASE_INDEX;
            acc_reg         <= '0;
            lit_bytes_reg   <= '0;
            lit_count_reg   <= '0;
            remain_reg      <= '0;
        end
        else
        begin
            table_count_reg <= table_count_next;
            phase_reg       <= phase_next;
            acc_reg         <= acc_next;
            lit_bytes_reg   <= lit_bytes_next;
            lit_count_reg   <= lit_count_next;
            remain_reg      <= remain_next;
        end
    end

    // output register with skid: refill from skid first, else take the new beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_gen;
            end
        end
        else if (res_gen)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (res_gen)
        begin
            skid_reg <= res;
        end
    end

    prle_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (table_count_reg[TABLE_AW-1:0]),
        .wr_data (payload),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while the output register is empty");

    a_range_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == ST_RANGE) |-> out_reg.frame_last)
        else $error("index error beat does not end the frame");

    a_lit_count_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (lit_count_reg != 2'd0) |-> (phase_reg == PHASE_LITERAL))
        else $error("literal bytes held outside the literal phase");

    a_acc_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg != 32'd0) |-> (phase_reg != PHASE_LITERAL))
        else $error("accumulator not cleared on entering the literal phase");

    a_range_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (res_gen && res.status == ST_RANGE) |=> (remain_reg == 32'd0))
        else $error("frame not aborted after an index error");

endmodule

`default_nettype wire

FILE: rtl/prle_ram.sv
`default_nettype none

module prle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                                       clk,
    input  wire                                       wr_en,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire  [WIDTH-1:0]                          wr_data,
    input  wire                                       rd_en,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: bench/palette_run_length_expander_tb.sv
`timescale 1ns / 100ps

module palette_run_length_expander_tb;

    import prle_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned HOLD_LEN    = 300;

    localparam mode_t MODE_SPARE_5 = 3'd5;
    localparam mode_t MODE_SPARE_6 = 3'd6;
    localparam mode_t MODE_SPARE_7 = 3'd7;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_valid    = 1'b0;
    cfg_index_t  cfg_index    = CFG_FRAME_WIDTH;
    logic [15:0] cfg_data     = '0;
    logic        item_valid   = 1'b0;
    mode_t       item_mode    = MODE_START;
    logic [31:0] item_payload = '0;
    logic        result_stall = 1'b0;

    wire        cfg_ready;
    wire        item_stall;
    wire        result_valid;
    wire [31:0] pair_value;
    wire [31:0] repeat_count;
    wire        frame_last;
    wire [1:0]  status;

    palette_run_length_expander u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (item_mode),
        .payload      (item_payload),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pair_value   (pair_value),
        .repeat_count (repeat_count),
        .frame_last   (frame_last),
        .status       (status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // decoder copy
    logic [15:0] cfg_w = 16'd1;
    logic [15:0] cfg_h = 16'd1;
    logic [31:0] palette_copy [TABLE_DEPTH];
    int unsigned pal_count  = 0;
    phase_t      phase      = PHASE_INDEX;
    logic [31:0] acc        = '0;
    logic [31:0] held_index = '0;
    logic [23:0] lit_bytes  = '0;
    logic [1:0]  lit_cnt    = '0;
    logic [31:0] pairs_left = '0;

    result_t decoded_q [$];

    int unsigned items_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned frames_started = 0;
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;
    int unsigned idle_pct       = 0;
    int unsigned stall_pct      = 0;
    int unsigned hold_goal      = 0;
    int unsigned held_cycles    = 0;

    result_t got_beat;
    result_t want_beat;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hffff_ffff : s[31:0];
    endfunction

    function automatic void expect_beat(input logic [31:0] pair, input logic [31:0] count,
                                        input logic last, input status_t st);
        result_t r;
        r.pair_value   = pair;
        r.repeat_count = count;
        r.frame_last   = last;
        r.status       = st;
        decoded_q.push_back(r);
    endfunction

    function automatic logic take_byte(input logic [7:0] b, output logic [31:0] value);
        if (b == ESC_BYTE)
        begin
            acc   = sat_add(acc, 32'h0000_00ff);
            value = '0;
            return 1'b0;
        end
        value = sat_add(acc, {24'd0, b});
        acc   = '0;
        return 1'b1;
    endfunction

    function automatic void decode_beat(input mode_t m, input logic [31:0] p);
        logic [7:0]  b;
        logic [63:0] pixels;
        logic [31:0] value;
        logic [31:0] run;
        logic [31:0] count;
        logic [31:0] slot;
        phase_t      want;
        b = p[7:0];
        if (m == MODE_START)
        begin
            pixels     = {48'd0, cfg_w} * {48'd0, cfg_h};
            pairs_left = 32'((pixels + 64'd1) >> 1);
            pal_count  = 0;
            phase      = PHASE_INDEX;
            acc        = '0;
            held_index = '0;
            lit_bytes  = '0;
            lit_cnt    = '0;
            frames_started++;
            return;
        end
        if (m == MODE_TABLE)
        begin
            if (pal_count < TABLE_DEPTH)
            begin
                palette_copy[pal_count] = p;
                pal_count++;
            end
            return;
        end
        if (m > MODE_LITERAL)
            return;
        if (pairs_left == 0)
        begin
            expect_beat('0, '0, 1'b0, ST_END);
            return;
        end
        want = (m == MODE_INDEX) ? PHASE_INDEX : (m == MODE_RUN) ? PHASE_RUN : PHASE_LITERAL;
        if (phase != want)
        begin
            expect_beat('0, '0, 1'b0, ST_STREAM);
            return;
        end
        if (m == MODE_INDEX)
        begin
            if (!take_byte(b, value))
                return;
            if (value == 0)
            begin
                phase     = PHASE_LITERAL;
                lit_bytes = '0;
                lit_cnt   = '0;
            end
            else if (value - 32'd1 >= pal_count)
            begin
                pairs_left = '0;
                phase      = PHASE_INDEX;
                expect_beat('0, '0, 1'b1, ST_RANGE);
            end
            else
            begin
                held_index = value;
                phase      = PHASE_RUN;
            end
            return;
        end
        if (m == MODE_RUN)
        begin
            if (!take_byte(b, value))
                return;
            run        = sat_add(value, 32'd1);
            count      = (run < pairs_left) ? run : pairs_left;
            pairs_left = pairs_left - count;
            phase      = PHASE_INDEX;
            slot       = held_index - 32'd1;
            expect_beat((slot < TABLE_DEPTH) ? palette_copy[slot] : '0, count,
                        pairs_left == 0, ST_OK);
            return;
        end
        if (lit_cnt != LIT_LAST_BYTE)
        begin
            lit_bytes = lit_bytes | ({16'd0, b} << (8 * lit_cnt));
            lit_cnt   = lit_cnt + 2'd1;
            return;
        end
        value      = {b, lit_bytes};
        lit_bytes  = '0;
        lit_cnt    = '0;
        phase      = PHASE_INDEX;
        pairs_left = pairs_left - 32'd1;
        expect_beat(value, 32'd1, pairs_left == 0, ST_OK);
    endfunction

    // receiver: long hold when asked, random stall otherwise
    always @(posedge clk)
    begin
        if (held_cycles < hold_goal)
        begin
            result_stall <= 1'b1;
            held_cycles  <= held_cycles + 1;
        end
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            got_beat = {pair_value, repeat_count, frame_last, status};
            results_seen++;
            if (decoded_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: pair %h count %0d last %b status %0d",
                             pair_value, repeat_count, frame_last, status);
            end
            else
            begin
                want_beat = decoded_q.pop_front();
                if (got_beat !== want_beat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: expected pair %h count %0d last %b status %0d,",
                                  " got pair %h count %0d last %b status %0d"},
                                 results_seen, want_beat.pair_value, want_beat.repeat_count,
                                 want_beat.frame_last, want_beat.status, pair_value,
                                 repeat_count, frame_last, status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, decoded_q.size());
            $display("palette_run_length_expander test failed");
            $finish;
        end
    end

    function automatic logic [31:0] byte_word(input logic [7:0] b);
        return ($urandom & 32'hffff_ff00) | {24'd0, b};
    endfunction

    task automatic send_item(input mode_t m, input logic [31:0] p);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid   <= 1'b1;
        item_mode    <= m;
        item_payload <= p;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        decode_beat(m, p);
        items_sent++;
    endtask

    // split a value into 0xff continuation bytes and a closing byte
    task automatic send_value(input mode_t m, input int unsigned v);
        logic [31:0] rest;
        rest = v;
        while (rest >= 255)
        begin
            send_item(m, byte_word(ESC_BYTE));
            rest = rest - 255;
        end
        send_item(m, byte_word(rest[7:0]));
    endtask

    task automatic wait_decoder_idle();
        item_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_frame_size(input logic [15:0] w, input logic [15:0] h);
        logic        first_h;
        int          i;
        cfg_index_t  idx;
        logic [15:0] d;
        wait_decoder_idle();
        first_h = $urandom_range(1);
        for (i = 0; i < 2; i++)
        begin
            idx = (first_h ^ (i == 1)) ? CFG_FRAME_HEIGHT : CFG_FRAME_WIDTH;
            d   = (idx == CFG_FRAME_HEIGHT) ? h : w;
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= d;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            if (idx == CFG_FRAME_WIDTH)
                cfg_w = d;
            else
                cfg_h = d;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_before_frame();
        send_item(MODE_INDEX, byte_word(8'h01));
        send_item(MODE_RUN, byte_word(8'h00));
        send_item(MODE_LITERAL, byte_word(8'h7e));
        send_item(MODE_SPARE_5, $urandom);
        send_item(MODE_SPARE_6, $urandom);
        send_item(MODE_SPARE_7, $urandom);
    endtask

    task automatic test_small_frame();
        set_frame_size(16'd3, 16'd3);
        send_item(MODE_START, $urandom);
        send_item(MODE_TABLE, 32'hffff_ffff);
        send_item(MODE_TABLE, 32'h0000_0000);
        send_item(MODE_TABLE, 32'h5a5a_a5a5);
        send_item(MODE_INDEX, byte_word(8'h01));
        send_item(MODE_RUN, byte_word(8'h00));
        send_item(MODE_RUN, byte_word(8'h03));
        send_item(MODE_LITERAL, byte_word(8'h44));
        send_item(MODE_INDEX, byte_word(8'h03));
        send_item(MODE_INDEX, byte_word(8'h02));
        send_item(MODE_RUN, byte_word(8'h01));
        send_item(MODE_INDEX, byte_word(8'h00));
        send_item(MODE_LITERAL, byte_word(8'h11));
        send_item(MODE_LITERAL, byte_word(8'h22));
        send_item(MODE_LITERAL, byte_word(8'h33));
        send_item(MODE_LITERAL, byte_word(8'hff));
        // run longer than what is left: clamp and close the frame
        send_item(MODE_INDEX, byte_word(8'h02));
        send_item(MODE_RUN, byte_word(8'hc8));
        send_item(MODE_INDEX, byte_word(8'h01));
    endtask

    task automatic test_index_beyond_table();
        set_frame_size(16'd16, 16'd16);
        send_item(MODE_START, $urandom);
        send_item(MODE_TABLE, $urandom);
        send_item(MODE_TABLE, $urandom);
        send_value(MODE_INDEX, 3);
        send_item(MODE_RUN, byte_word(8'h00));
    endtask

    task automatic test_empty_frame();
        set_frame_size(16'd0, 16'd5);
        send_item(MODE_START, $urandom);
        send_item(MODE_INDEX, byte_word(8'h00));
        set_frame_size(16'd7, 16'd0);
        send_item(MODE_START, $urandom);
        send_item(MODE_LITERAL, byte_word(8'h00));
    endtask

    task automatic test_frame_extremes();
        set_frame_size(16'hffff, 16'hffff);
        send_item(MODE_START, $urandom);
        send_item(MODE_TABLE, $urandom);
        send_item(MODE_INDEX, byte_word(8'h01));
        send_value(MODE_RUN, 600);
        send_item(MODE_INDEX, byte_word(8'h00));
        repeat (4) send_item(MODE_LITERAL, byte_word(8'h00));
        set_frame_size(16'd1, 16'd1);
        send_item(MODE_START, $urandom);
        send_item(MODE_INDEX, byte_word(8'h00));
        repeat (4) send_item(MODE_LITERAL, byte_word(8'($urandom)));
    endtask

    task automatic test_table_full();
        set_frame_size(16'd64, 16'd64);
        send_item(MODE_START, $urandom);
        repeat (TABLE_DEPTH + 1) send_item(MODE_TABLE, $urandom);
        send_value(MODE_INDEX, TABLE_DEPTH);
        send_item(MODE_RUN, byte_word(8'h00));
        send_value(MODE_INDEX, TABLE_DEPTH + 1);
    endtask

    task automatic test_backpressure();
        set_frame_size(16'd64, 16'd64);
        idle_pct  = 0;
        stall_pct = 0;
        send_item(MODE_START, $urandom);
        repeat (4) send_item(MODE_TABLE, $urandom);
        hold_goal <= hold_goal + HOLD_LEN;
        repeat (30)
        begin
            send_item(MODE_INDEX, byte_word(8'($urandom_range(1, 4))));
            send_item(MODE_RUN, byte_word(8'($urandom_range(0, 3))));
        end
    endtask

    function automatic logic [15:0] pick_dim(input int unsigned typical_max);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 82)
            return 16'($urandom_range(1, typical_max));
        if (r < 90)
            return 16'($urandom_range(0, 65535));
        if (r < 96)
            return 16'hffff;
        return 16'd0;
    endfunction

    task automatic test_random(input int unsigned send_idle, input int unsigned recv_stall,
                               input int unsigned n);
        int unsigned first_item;
        int unsigned ntab;
        int unsigned entries;
        int unsigned r;
        int unsigned k;
        first_item = items_sent;
        while (items_sent - first_item < n)
        begin
            set_frame_size(pick_dim(16), pick_dim(8));
            idle_pct  = send_idle;
            stall_pct = recv_stall;
            send_item(MODE_START, $urandom);
            ntab = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(250, 300);
            repeat (ntab) send_item(MODE_TABLE, $urandom);
            entries = 0;
            while (pairs_left != 0 && entries < 40)
            begin
                r = $urandom_range(99);
                if (r < 8)
                    send_item(mode_t'($urandom_range(MODE_TABLE, MODE_SPARE_7)), $urandom);
                else if (r < 11)
                    send_value(MODE_INDEX, ntab + 1 + $urandom_range(0, 3));
                else if (r < 30)
                begin
                    send_item(MODE_INDEX, byte_word(8'h00));
                    repeat (4) send_item(MODE_LITERAL, byte_word(8'($urandom)));
                end
                else
                begin
                    send_value(MODE_INDEX, $urandom_range(1, ntab));
                    k = $urandom_range(99);
                    if (k < 85)
                        send_value(MODE_RUN, $urandom_range(0, 10));
                    else if (k < 95)
                        send_value(MODE_RUN, $urandom_range(0, 254));
                    else
                        send_value(MODE_RUN, $urandom_range(255, 700));
                end
                entries++;
            end
            repeat ($urandom_range(0, 2))
                send_item(mode_t'($urandom_range(MODE_INDEX, MODE_LITERAL)), $urandom);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_before_frame();
        test_small_frame();
        test_index_beyond_table();
        test_empty_frame();
        test_frame_extremes();
        test_table_full();
        test_backpressure();
        test_random(0, 0, 165);
        test_random(68, 0, 165);
        test_random(0, 68, 165);
        test_random(29, 29, 165);

        wait_decoder_idle();
        if (decoded_q.size() != 0)
            mismatches += decoded_q.size();

        $display("sent %0d input beats over %0d frames, checked %0d result beats, %0d mismatches",
                 items_sent, frames_started, results_seen, mismatches);
        $display("covered stream errors, table overflow, range aborts, size extremes and stalls");
        if (mismatches == 0)
            $display("palette_run_length_expander test passed");
        else
            $display("palette_run_length_expander test failed");
        $finish;
    end

endmodule
